FILE: rtl/windowed_direction_average_macros.svh
// assertion macros shared by the rtl
// every macro samples on clk and is disabled while arst_n is low
`ifndef WINDOWED_DIRECTION_AVERAGE_MACROS_SVH
`define WINDOWED_DIRECTION_AVERAGE_MACROS_SVH

// same-cycle implication
`define WDA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wda assertion failed");

// next-cycle implication
`define WDA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wda assertion failed");

`endif

FILE: rtl/wda_pkg.sv
package wda_pkg;

	// window and sample format
	localparam int WINDOW      = 16;
	localparam int SAMPLE_BITS = 16;

	// derived widths
	localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W  = $clog2(WINDOW + 1);
	localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
	localparam int PROD_W  = 2 * SUM_W;
	localparam int SQ_W    = PROD_W + 1;
	localparam int ROOT_W  = (SQ_W + 1) / 2;
	localparam int DIV_W   = ROOT_W + 1;
	localparam int ENTRY_W = 2 * SAMPLE_BITS;

	// unit vector format, q1.14
	localparam int UNIT_W    = 16;
	localparam int UNIT_FRAC = 14;
	localparam int UNIT_ONE  = 1 << UNIT_FRAC;
	localparam int Q_W       = UNIT_FRAC + 1;
	localparam int DIV_STEPS = Q_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_x;
		logic signed [SAMPLE_BITS-1:0] sample_y;
	} wda_sample_t;

	typedef struct packed {
		logic signed [UNIT_W-1:0] unit_x;
		logic signed [UNIT_W-1:0] unit_y;
		logic                     zero_sum;
	} wda_unit_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_x;
		logic signed [SUM_W-1:0] sum_y;
	} wda_sums_t;

	typedef enum logic [1:0] {
		RING_IDLE,
		RING_UPDATE,
		RING_SEND
	} wda_ring_state_t;

	typedef enum logic [2:0] {
		NORM_IDLE,
		NORM_SQX,
		NORM_SQY,
		NORM_ROOT,
		NORM_PREP,
		NORM_DIV,
		NORM_DONE
	} wda_norm_state_t;

endpackage

FILE: rtl/windowed_direction_average.sv
// each sample transaction goes through the ring update and then the normalise unit, which is shared
// by all transactions: it squares both sums, takes the root one bit at a time, then divides each
// component bit by bit and registers the result; a zero sum skips the division
// the ring update overlaps with the previous normalise, so the ring can accept a new sample meanwhile
// reset clears sums, fill count, write slot and handshake state; ring contents stay undefined
module windowed_direction_average (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  wda_pkg::wda_sample_t sample,
	output logic                 unit_valid,
	input  logic                 unit_stall,
	output wda_pkg::wda_unit_t   unit
);

	logic               sums_valid;
	logic               sums_ready;
	wda_pkg::wda_sums_t sums;

	// window ring and running sums
	wda_ring u_ring (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.sums_valid   (sums_valid),
		.sums_ready   (sums_ready),
		.sums         (sums)
	);

	// magnitude and unit direction
	wda_norm u_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.sums_valid (sums_valid),
		.sums_ready (sums_ready),
		.sums       (sums),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit       (unit)
	);

endmodule

FILE: rtl/wda_ram.sv
module wda_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/wda_ring.sv
module wda_ring (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  wda_pkg::wda_sample_t sample,
	output logic                 sums_valid,
	input  logic                 sums_ready,
	output wda_pkg::wda_sums_t   sums
);

	wda_pkg::wda_ring_state_t state_q, state_d;

	wda_pkg::wda_sample_t                 sample_q;
	logic [wda_pkg::SLOT_W-1:0]           slot_q;
	logic [wda_pkg::FILL_W-1:0]           fill_q;
	logic signed [wda_pkg::SUM_W-1:0]     sum_x_q, sum_y_q;

	logic                                 rd_en;
	logic                                 wr_en;
	logic [wda_pkg::ENTRY_W-1:0]          rdata;
	logic                                 full;
	logic signed [wda_pkg::SAMPLE_BITS-1:0] old_x, old_y;
	logic signed [wda_pkg::SUM_W-1:0]     drop_x, drop_y;

	// ring of past samples
	wda_ram #(
		.WIDTH (wda_pkg::ENTRY_W),
		.DEPTH (wda_pkg::WINDOW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot_q),
		.wdata ({sample_q.sample_x, sample_q.sample_y}),
		.re    (rd_en),
		.raddr (slot_q),
		.rdata (rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wda_pkg::RING_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		sums_valid   = 1'b0;
		rd_en        = 1'b0;
		wr_en        = 1'b0;
		case (state_q)
			wda_pkg::RING_IDLE: begin
				sample_stall = 1'b0;
				rd_en        = sample_valid;
				if (sample_valid) begin
					state_d = wda_pkg::RING_UPDATE;
				end
			end
			wda_pkg::RING_UPDATE: begin
				wr_en   = 1'b1;
				state_d = wda_pkg::RING_SEND;
			end
			wda_pkg::RING_SEND: begin
				sums_valid = 1'b1;
				if (sums_ready) begin
					state_d = wda_pkg::RING_IDLE;
				end
			end
			default: begin
				state_d = wda_pkg::RING_IDLE;
			end
		endcase
	end

	// oldest sample leaves the window once the ring is full
	assign full   = (fill_q == wda_pkg::FILL_W'(wda_pkg::WINDOW));
	assign old_x  = rdata[wda_pkg::ENTRY_W-1:wda_pkg::SAMPLE_BITS];
	assign old_y  = rdata[wda_pkg::SAMPLE_BITS-1:0];
	assign drop_x = full ? wda_pkg::SUM_W'(old_x) : '0;
	assign drop_y = full ? wda_pkg::SUM_W'(old_y) : '0;

	// sample capture
	always_ff @(posedge clk) begin
		if (state_q == wda_pkg::RING_IDLE && sample_valid) begin
			sample_q <= sample;
		end
	end

	// running sums, fill count and write slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			fill_q  <= '0;
			slot_q  <= '0;
		end else if (wr_en) begin
			sum_x_q <= sum_x_q - drop_x + wda_pkg::SUM_W'(sample_q.sample_x);
			sum_y_q <= sum_y_q - drop_y + wda_pkg::SUM_W'(sample_q.sample_y);
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
			if (slot_q == wda_pkg::SLOT_W'(wda_pkg::WINDOW - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	assign sums.sum_x = sum_x_q;
	assign sums.sum_y = sum_y_q;

endmodule

FILE: rtl/wda_norm.sv
`include "windowed_direction_average_macros.svh"

module wda_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sums_valid,
	output logic               sums_ready,
	input  wda_pkg::wda_sums_t sums,
	output logic               unit_valid,
	input  logic               unit_stall,
	output wda_pkg::wda_unit_t unit
);

	localparam logic [wda_pkg::SQ_W-1:0] BIT_INIT =
		wda_pkg::SQ_W'(1) << (2 * (wda_pkg::ROOT_W - 1));

	wda_pkg::wda_norm_state_t state_q, state_d;

	logic [wda_pkg::SUM_W-1:0]   ax_q, ay_q;
	logic                        neg_x_q, neg_y_q;
	logic [wda_pkg::PROD_W-1:0]  sq_q;
	logic [wda_pkg::SQ_W-1:0]    rem_q, root_q, bit_q;
	logic [wda_pkg::DIV_W-1:0]   rx_q, ry_q;
	logic [wda_pkg::Q_W-1:0]     qx_q, qy_q;
	logic [wda_pkg::CNT_W-1:0]   cnt_q;
	logic                        out_valid_q;
	wda_pkg::wda_unit_t          out_q;

	logic [wda_pkg::SUM_W-1:0]   abs_x, abs_y;
	logic [wda_pkg::SUM_W-1:0]   mul_op;
	logic [wda_pkg::PROD_W-1:0]  prod;
	logic [wda_pkg::SQ_W:0]      trial;
	logic                        root_ge;
	logic [wda_pkg::ROOT_W-1:0]  mag;
	logic                        mag_zero;
	logic                        ge_x, ge_y;
	logic [wda_pkg::DIV_W-1:0]   rx_sub, ry_sub;
	logic [wda_pkg::Q_W-1:0]     sat_x, sat_y;
	logic                        load_out;
	wda_pkg::wda_unit_t          result;

	// magnitudes of the incoming sums
	assign abs_x = sums.sum_x[wda_pkg::SUM_W-1] ? $unsigned(-sums.sum_x) : $unsigned(sums.sum_x);
	assign abs_y = sums.sum_y[wda_pkg::SUM_W-1] ? $unsigned(-sums.sum_y) : $unsigned(sums.sum_y);

	// shared squaring multiplier
	assign mul_op = (state_q == wda_pkg::NORM_SQX) ? ax_q : ay_q;
	assign prod   = wda_pkg::PROD_W'(mul_op) * wda_pkg::PROD_W'(mul_op);

	// one root bit per cycle
	assign trial   = {1'b0, root_q} + {1'b0, bit_q};
	assign root_ge = ({1'b0, rem_q} >= trial);
	assign mag      = root_q[wda_pkg::ROOT_W-1:0];
	assign mag_zero = (root_q == '0);

	// one quotient bit per cycle on each component
	assign ge_x   = (rx_q >= wda_pkg::DIV_W'(mag));
	assign ge_y   = (ry_q >= wda_pkg::DIV_W'(mag));
	assign rx_sub = ge_x ? rx_q - wda_pkg::DIV_W'(mag) : rx_q;
	assign ry_sub = ge_y ? ry_q - wda_pkg::DIV_W'(mag) : ry_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wda_pkg::NORM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d    = state_q;
		sums_ready = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			wda_pkg::NORM_IDLE: begin
				sums_ready = 1'b1;
				if (sums_valid) begin
					state_d = wda_pkg::NORM_SQX;
				end
			end
			wda_pkg::NORM_SQX: begin
				state_d = wda_pkg::NORM_SQY;
			end
			wda_pkg::NORM_SQY: begin
				state_d = wda_pkg::NORM_ROOT;
			end
			wda_pkg::NORM_ROOT: begin
				if (bit_q[0]) begin
					state_d = wda_pkg::NORM_PREP;
				end
			end
			wda_pkg::NORM_PREP: begin
				state_d = mag_zero ? wda_pkg::NORM_DONE : wda_pkg::NORM_DIV;
			end
			wda_pkg::NORM_DIV: begin
				if (cnt_q == wda_pkg::CNT_W'(wda_pkg::DIV_STEPS - 1)) begin
					state_d = wda_pkg::NORM_DONE;
				end
			end
			wda_pkg::NORM_DONE: begin
				if (!out_valid_q || !unit_stall) begin
					load_out = 1'b1;
					state_d  = wda_pkg::NORM_IDLE;
				end
			end
			default: begin
				state_d = wda_pkg::NORM_IDLE;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			wda_pkg::NORM_IDLE: begin
				ax_q    <= abs_x;
				ay_q    <= abs_y;
				neg_x_q <= sums.sum_x[wda_pkg::SUM_W-1];
				neg_y_q <= sums.sum_y[wda_pkg::SUM_W-1];
			end
			wda_pkg::NORM_SQX: begin
				sq_q <= prod;
			end
			wda_pkg::NORM_SQY: begin
				rem_q  <= wda_pkg::SQ_W'(sq_q) + wda_pkg::SQ_W'(prod);
				root_q <= '0;
				bit_q  <= BIT_INIT;
			end
			wda_pkg::NORM_ROOT: begin
				if (root_ge) begin
					rem_q  <= rem_q - trial[wda_pkg::SQ_W-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			wda_pkg::NORM_PREP: begin
				rx_q  <= wda_pkg::DIV_W'(ax_q);
				ry_q  <= wda_pkg::DIV_W'(ay_q);
				qx_q  <= '0;
				qy_q  <= '0;
				cnt_q <= '0;
			end
			wda_pkg::NORM_DIV: begin
				rx_q  <= {rx_sub[wda_pkg::DIV_W-2:0], 1'b0};
				ry_q  <= {ry_sub[wda_pkg::DIV_W-2:0], 1'b0};
				qx_q  <= {qx_q[wda_pkg::Q_W-2:0], ge_x};
				qy_q  <= {qy_q[wda_pkg::Q_W-2:0], ge_y};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// saturate, apply sign, flag a zero sum
	assign sat_x = (qx_q > wda_pkg::Q_W'(wda_pkg::UNIT_ONE)) ? wda_pkg::Q_W'(wda_pkg::UNIT_ONE) : qx_q;
	assign sat_y = (qy_q > wda_pkg::Q_W'(wda_pkg::UNIT_ONE)) ? wda_pkg::Q_W'(wda_pkg::UNIT_ONE) : qy_q;

	always_comb begin
		result.zero_sum = mag_zero;
		if (mag_zero) begin
			result.unit_x = '0;
			result.unit_y = '0;
		end else begin
			result.unit_x = neg_x_q ? -$signed(wda_pkg::UNIT_W'(sat_x)) : $signed(wda_pkg::UNIT_W'(sat_x));
			result.unit_y = neg_y_q ? -$signed(wda_pkg::UNIT_W'(sat_y)) : $signed(wda_pkg::UNIT_W'(sat_y));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!unit_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= result;
		end
	end

	assign unit_valid = out_valid_q;
	assign unit       = out_q;

	// quotients never exceed one since each component is at most the magnitude
	`WDA_ASSERT_IMP(a_quot_le_one, state_q == wda_pkg::NORM_DONE && !mag_zero,
		qx_q <= wda_pkg::Q_W'(wda_pkg::UNIT_ONE) && qy_q <= wda_pkg::Q_W'(wda_pkg::UNIT_ONE))
	// final root fits the magnitude width
	`WDA_ASSERT_IMP(a_root_fits, state_q == wda_pkg::NORM_PREP,
		(root_q >> wda_pkg::ROOT_W) == '0)
	// a handed-over sum always starts the squaring step
	`WDA_ASSERT_NXT(a_start_sq, state_q == wda_pkg::NORM_IDLE && sums_valid,
		state_q == wda_pkg::NORM_SQX)
	// an output load never overwrites a result still waiting
	`WDA_ASSERT_IMP(a_no_overwrite, load_out, !out_valid_q || !unit_stall)

endmodule
